// ----- sv/dcfa_pkg.sv -----
// ----------------------------------------------------------------------------
// dcfa_pkg
// Shared types, constants and saturation helpers for the contact force
// accumulator.
// ----------------------------------------------------------------------------
package dcfa_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int WORD_BITS    = 32;
	localparam int IW           = WORD_BITS + 1;
	localparam int CW           = (IW + 2 > 34) ? IW + 2 : 34;
	localparam int MW           = 2 * IW;
	localparam int REG_BITS     = 32;
	localparam int CFG_IDX_BITS = 2;

	typedef logic signed [IW-1:0]        word_t;
	typedef logic signed [CW-1:0]        cword_t;
	typedef logic signed [WORD_BITS-1:0] fsum_t;
	typedef logic        [MW-1:0]        mag_t;

	typedef struct packed {
		logic  sat;
		word_t v;
	} wsat_t;

	typedef struct packed {
		logic  sat;
		fsum_t v;
	} fsat_t;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} alu_rsp_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_GRAV_X,
		CFG_GRAV_Y,
		CFG_GRAV_Z,
		CFG_TOL
	} cfg_idx_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_OWN_LOAD,
		ST_OWN_KPR,
		ST_OWN_GX,
		ST_OWN_GY,
		ST_OWN_GZ,
		ST_NB_LOAD,
		ST_NB_K2,
		ST_NB_C2,
		ST_NB_DX,
		ST_NB_DY,
		ST_NB_DZ,
		ST_NB_RS2,
		ST_NB_DIST,
		ST_NB_UX,
		ST_NB_UY,
		ST_NB_UZ,
		ST_NB_KSUM,
		ST_NB_KPROD,
		ST_NB_KEQ,
		ST_NB_GAP,
		ST_NB_FE,
		ST_NB_DAMP,
		ST_NB_MSUM,
		ST_NB_MPROD,
		ST_NB_MRED,
		ST_NB_KM,
		ST_NB_SQ,
		ST_NB_CRIT,
		ST_NB_COEF,
		ST_NB_VX,
		ST_NB_VY,
		ST_NB_VZ,
		ST_NB_FN,
		ST_NB_FX,
		ST_NB_FY,
		ST_NB_FZ,
		ST_OUT
	} st_t;

	localparam logic signed [REG_BITS-1:0] GRAV_Z_RESET = -32'sd642253;

	localparam cword_t WIDE_MAX_C = (cword_t'(1) <<< WORD_BITS) - cword_t'(1);
	localparam cword_t WIDE_MIN_C = -(cword_t'(1) <<< WORD_BITS);
	localparam cword_t OUT_MAX_C  = (cword_t'(1) <<< (WORD_BITS - 1)) - cword_t'(1);
	localparam cword_t OUT_MIN_C  = -(cword_t'(1) <<< (WORD_BITS - 1));
	localparam mag_t   POW_W      = mag_t'(1) << WORD_BITS;
	localparam mag_t   HUGE_MAG   = POW_W + mag_t'(1);

	function automatic wsat_t clampw(cword_t x);
		wsat_t r;
		r.sat = 1'b0;
		r.v   = x[IW-1:0];
		if (x > WIDE_MAX_C) begin
			r.sat = 1'b1;
			r.v   = WIDE_MAX_C[IW-1:0];
		end else if (x < WIDE_MIN_C) begin
			r.sat = 1'b1;
			r.v   = WIDE_MIN_C[IW-1:0];
		end
		return r;
	endfunction

	function automatic fsat_t clampo(cword_t x);
		fsat_t r;
		r.sat = 1'b0;
		r.v   = x[WORD_BITS-1:0];
		if (x > OUT_MAX_C) begin
			r.sat = 1'b1;
			r.v   = OUT_MAX_C[WORD_BITS-1:0];
		end else if (x < OUT_MIN_C) begin
			r.sat = 1'b1;
			r.v   = OUT_MIN_C[WORD_BITS-1:0];
		end
		return r;
	endfunction

	// signed result from sign and magnitude, saturating to the internal range
	function automatic wsat_t from_mag(logic neg, mag_t mag);
		wsat_t          r;
		logic [IW-1:0]  low;
		low   = mag[IW-1:0];
		r.sat = 1'b0;
		if (neg) begin
			if (mag > POW_W) begin
				r.sat = 1'b1;
				r.v   = WIDE_MIN_C[IW-1:0];
			end else begin
				r.v = -$signed(low);
			end
		end else begin
			if (mag > POW_W - mag_t'(1)) begin
				r.sat = 1'b1;
				r.v   = WIDE_MAX_C[IW-1:0];
			end else begin
				r.v = $signed(low);
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/dcfa_alu.sv -----
// ----------------------------------------------------------------------------
// dcfa_alu
// Shared fixed point unit: multiply, bit-serial restoring divide,
// two-bits-per-cycle square root. All results truncate and saturate.
// ----------------------------------------------------------------------------
module dcfa_alu import dcfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	input  word_t    a,
	input  word_t    b,
	output alu_rsp_t rsp,
	output word_t    result
);

	localparam int DW   = IW + FRAC_BITS;
	localparam int NP   = (DW + 1) / 2;
	localparam int CNTW = $clog2(DW + 1);

	logic             busy_q;
	alu_op_t          op_q;
	logic [CNTW-1:0]  cnt_q;
	logic             neg_q;
	logic             dz_q;
	mag_t             prod_q;
	logic [DW-1:0]    num_q;
	logic [DW-1:0]    quo_q;
	logic [IW-1:0]    rem_q;
	logic [IW-1:0]    den_q;
	logic [2*NP-1:0]  sx_q;
	logic [NP+1:0]    srem_q;
	logic [NP-1:0]    root_q;

	logic [IW-1:0]    a_mag;
	logic [IW-1:0]    b_mag;
	logic [IW:0]      dtrial;
	logic             dge;
	logic [NP+1:0]    strial;
	logic [NP+1:0]    stest;
	logic             sge;
	logic             step;
	wsat_t            fm;

	assign a_mag  = a[IW-1] ? -a : a;
	assign b_mag  = b[IW-1] ? -b : b;
	assign dtrial = {rem_q, num_q[DW-1]};
	assign dge    = dtrial >= {1'b0, den_q};
	assign strial = {srem_q[NP-1:0], sx_q[2*NP-1 -: 2]};
	assign stest  = {root_q, 2'b01};
	assign sge    = strial >= stest;
	assign step   = busy_q && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			case (req.op)
				ALU_DIV:  cnt_q <= (b_mag == '0) ? '0 : CNTW'(DW);
				ALU_SQRT: cnt_q <= CNTW'(NP);
				default:  cnt_q <= '0;
			endcase
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNTW'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			neg_q <= a[IW-1] ^ b[IW-1];
			dz_q  <= (b_mag == '0);
			case (req.op)
				ALU_MUL: begin
					prod_q <= mag_t'(a_mag) * mag_t'(b_mag);
				end
				ALU_DIV: begin
					num_q <= {a_mag, {FRAC_BITS{1'b0}}};
					den_q <= b_mag;
					rem_q <= '0;
					quo_q <= '0;
				end
				ALU_SQRT: begin
					if (a[IW-1] || (a == '0)) begin
						sx_q <= '0;
					end else begin
						sx_q <= (2*NP)'({a[IW-1:0], {FRAC_BITS{1'b0}}});
					end
					srem_q <= '0;
					root_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (step) begin
			case (op_q)
				ALU_DIV: begin
					num_q <= {num_q[DW-2:0], 1'b0};
					quo_q <= {quo_q[DW-2:0], dge};
					rem_q <= dge ? IW'(dtrial - {1'b0, den_q}) : IW'(dtrial);
				end
				ALU_SQRT: begin
					sx_q   <= {sx_q[2*NP-3:0], 2'b00};
					srem_q <= sge ? strial - stest : strial;
					root_q <= {root_q[NP-2:0], sge};
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			ALU_MUL:  fm = from_mag(neg_q, prod_q >> FRAC_BITS);
			ALU_DIV:  fm = from_mag(neg_q, dz_q ? HUGE_MAG : mag_t'(quo_q));
			ALU_SQRT: fm = from_mag(1'b0, mag_t'(root_q));
			default:  fm = '0;
		endcase
	end

	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.sat  = fm.sat;
	assign result   = fm.v;

endmodule

// ----- sv/dem_contact_force_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// dem_contact_force_accumulator_unit
// Linear spring-dashpot normal contact force accumulator, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Own-particle item: one divide and three multiplies. Neighbour item: up
// to six divides, two square roots and multiplies, all on the one shared
// ALU. One item at a time. After an item marked last, the result moves
// from ST_OUT into the output register once no held result blocks it;
// the next item can be taken while it waits in the output register.
// Reset clears own state, sums and flag; config returns to its reset values.
module dem_contact_force_accumulator_unit import dcfa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [REG_BITS-1:0]      cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [31:0]              mass,
	input  logic [31:0]              radius,
	input  logic [31:0]              stiffness,
	input  logic [17:0]              damping_ratio,
	input  logic signed [31:0]       pos_x,
	input  logic signed [31:0]       pos_y,
	input  logic signed [31:0]       pos_z,
	input  logic signed [31:0]       vel_x,
	input  logic signed [31:0]       vel_y,
	input  logic signed [31:0]       vel_z,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [31:0]       force_x,
	output logic signed [31:0]       force_y,
	output logic signed [31:0]       force_z,
	output logic                     saturated
);

	st_t state_q, state_d;

	logic signed [REG_BITS-1:0] grav_q [3];
	logic signed [REG_BITS-1:0] tol_q;

	word_t own_mass_q, own_radius_q, own_kpr_q, own_damp_q;
	word_t own_pos_q [3];
	word_t own_vel_q [3];
	fsum_t force_q [3];
	logic  sat_q;

	logic [31:0]        m_raw_q, r_raw_q, k_raw_q;
	logic [17:0]        dr_raw_q;
	logic signed [31:0] pos_raw_q [3];
	logic signed [31:0] vel_raw_q [3];
	logic               last_q;

	word_t m2_q, r2_q, damp2_q, rs_q, k2_q, c2_q, d2_q, dist_q, ksum_q, keq_q;
	word_t t_q, fe_q, fn_q, msum_q, mred_q, crit_q, coef_q, vn_q;
	word_t d_q [3];
	word_t u_q [3];
	word_t vrel_q [3];
	logic  vflag_q;

	logic               issued_q;
	logic               out_valid_q;
	logic signed [31:0] force_out_q [3];
	logic               sat_out_q;

	logic     accept;
	logic     compute;
	logic     uses_alu;
	logic     step_done;
	logic     out_load;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	alu_op_t  alu_op;
	word_t    alu_a, alu_b, alu_res;
	word_t    post_x, post_y;
	logic     post_sub;
	logic     use_pw, use_po;
	logic     extra_sat;
	cword_t   post_sum;
	wsat_t    pw;
	fsat_t    po;
	logic     fin_last;

	wsat_t cm, cr, ck, cdr, rsc;
	wsat_t cg [3];
	wsat_t cpos [3];
	wsat_t cvel [3];
	wsat_t dnb [3];
	wsat_t vr [3];
	logic  own_load_sat, nb_load_sat, vflag_c;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign compute  = (state_q != ST_IDLE) && (state_q != ST_OUT);
	assign fin_last = last_q;

	// input and config conditioning
	always_comb begin
		cm  = clampw(cword_t'({1'b0, m_raw_q}));
		cr  = clampw(cword_t'({1'b0, r_raw_q}));
		ck  = clampw(cword_t'({1'b0, k_raw_q}));
		cdr = clampw(cword_t'({1'b0, dr_raw_q}));
		rsc = clampw(cword_t'(own_radius_q) + cword_t'(cr.v));
		own_load_sat = cm.sat | cr.sat | ck.sat | cdr.sat;
		nb_load_sat  = cm.sat | cr.sat | ck.sat | cdr.sat | rsc.sat;
		vflag_c      = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cg[i]   = clampw(cword_t'(grav_q[i]));
			cpos[i] = clampw(cword_t'(pos_raw_q[i]));
			cvel[i] = clampw(cword_t'(vel_raw_q[i]));
			dnb[i]  = clampw(cword_t'(own_pos_q[i]) - cword_t'(cpos[i].v));
			vr[i]   = clampw(cword_t'(own_vel_q[i]) - cword_t'(cvel[i].v));
			own_load_sat = own_load_sat | cpos[i].sat | cvel[i].sat;
			nb_load_sat  = nb_load_sat | cpos[i].sat | dnb[i].sat;
			vflag_c      = vflag_c | cvel[i].sat | vr[i].sat;
		end
	end

	assign post_sum = post_sub ? cword_t'(post_x) - cword_t'(post_y)
	                           : cword_t'(post_x) + cword_t'(post_y);
	assign pw = clampw(post_sum);
	assign po = clampo(post_sum);

	assign alu_req.start = uses_alu && !issued_q;
	assign alu_req.op    = alu_op;
	assign step_done     = uses_alu ? alu_rsp.done : 1'b1;

	dcfa_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = mode ? ST_NB_LOAD : ST_OWN_LOAD;
			end
			ST_OWN_LOAD: state_d = ST_OWN_KPR;
			ST_OWN_KPR:  if (step_done) state_d = ST_OWN_GX;
			ST_OWN_GX:   if (step_done) state_d = ST_OWN_GY;
			ST_OWN_GY:   if (step_done) state_d = ST_OWN_GZ;
			ST_OWN_GZ:   if (step_done) state_d = fin_last ? ST_OUT : ST_IDLE;
			ST_NB_LOAD:  state_d = ST_NB_K2;
			ST_NB_K2:    if (step_done) state_d = ST_NB_C2;
			ST_NB_C2:    if (step_done) state_d = ST_NB_DX;
			ST_NB_DX:    if (step_done) state_d = ST_NB_DY;
			ST_NB_DY:    if (step_done) state_d = ST_NB_DZ;
			ST_NB_DZ:    if (step_done) state_d = ST_NB_RS2;
			ST_NB_RS2: begin
				if (step_done) begin
					if ((cword_t'(pw.v) < cword_t'(tol_q)) && (d2_q != '0)) begin
						state_d = ST_NB_DIST;
					end else begin
						state_d = fin_last ? ST_OUT : ST_IDLE;
					end
				end
			end
			ST_NB_DIST: begin
				if (step_done) begin
					if (alu_res != '0) state_d = ST_NB_UX;
					else state_d = fin_last ? ST_OUT : ST_IDLE;
				end
			end
			ST_NB_UX:    if (step_done) state_d = ST_NB_UY;
			ST_NB_UY:    if (step_done) state_d = ST_NB_UZ;
			ST_NB_UZ:    if (step_done) state_d = ST_NB_KSUM;
			ST_NB_KSUM:  state_d = (pw.v == '0) ? ST_NB_GAP : ST_NB_KPROD;
			ST_NB_KPROD: if (step_done) state_d = ST_NB_KEQ;
			ST_NB_KEQ:   if (step_done) state_d = ST_NB_GAP;
			ST_NB_GAP:   state_d = ST_NB_FE;
			ST_NB_FE:    if (step_done) state_d = ST_NB_DAMP;
			ST_NB_DAMP:  state_d = (cword_t'(pw.v) > cword_t'(tol_q)) ? ST_NB_MSUM : ST_NB_FX;
			ST_NB_MSUM:  state_d = (pw.v == '0) ? ST_NB_KM : ST_NB_MPROD;
			ST_NB_MPROD: if (step_done) state_d = ST_NB_MRED;
			ST_NB_MRED:  if (step_done) state_d = ST_NB_KM;
			ST_NB_KM:    if (step_done) state_d = ST_NB_SQ;
			ST_NB_SQ:    if (step_done) state_d = ST_NB_CRIT;
			ST_NB_CRIT:  state_d = ST_NB_COEF;
			ST_NB_COEF:  if (step_done) state_d = ST_NB_VX;
			ST_NB_VX:    if (step_done) state_d = ST_NB_VY;
			ST_NB_VY:    if (step_done) state_d = ST_NB_VZ;
			ST_NB_VZ:    if (step_done) state_d = ST_NB_FN;
			ST_NB_FN:    if (step_done) state_d = ST_NB_FX;
			ST_NB_FX:    if (step_done) state_d = ST_NB_FY;
			ST_NB_FY:    if (step_done) state_d = ST_NB_FZ;
			ST_NB_FZ:    if (step_done) state_d = fin_last ? ST_OUT : ST_IDLE;
			ST_OUT:      if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// operand routing per step
	always_comb begin
		uses_alu  = 1'b0;
		alu_op    = ALU_MUL;
		alu_a     = '0;
		alu_b     = '0;
		post_x    = '0;
		post_y    = alu_res;
		post_sub  = 1'b0;
		use_pw    = 1'b0;
		use_po    = 1'b0;
		extra_sat = 1'b0;
		case (state_q)
			ST_OWN_KPR: begin
				uses_alu = 1'b1; alu_op = ALU_DIV; alu_a = t_q; alu_b = own_radius_q;
			end
			ST_OWN_GX, ST_OWN_GY, ST_OWN_GZ: begin
				uses_alu = 1'b1; alu_a = own_mass_q; use_po = 1'b1;
				case (state_q)
					ST_OWN_GX: begin alu_b = cg[0].v; extra_sat = cg[0].sat; end
					ST_OWN_GY: begin alu_b = cg[1].v; extra_sat = cg[1].sat; end
					default:   begin alu_b = cg[2].v; extra_sat = cg[2].sat; end
				endcase
			end
			ST_NB_LOAD: extra_sat = nb_load_sat;
			ST_NB_K2: begin
				uses_alu = 1'b1; alu_op = ALU_DIV; alu_a = t_q; alu_b = r2_q;
			end
			ST_NB_C2: begin
				uses_alu = 1'b1; alu_a = damp2_q; alu_b = k2_q;
			end
			ST_NB_DX: begin
				uses_alu = 1'b1; alu_a = d_q[0]; alu_b = d_q[0]; use_pw = 1'b1;
			end
			ST_NB_DY: begin
				uses_alu = 1'b1; alu_a = d_q[1]; alu_b = d_q[1];
				post_x = d2_q; use_pw = 1'b1;
			end
			ST_NB_DZ: begin
				uses_alu = 1'b1; alu_a = d_q[2]; alu_b = d_q[2];
				post_x = d2_q; use_pw = 1'b1;
			end
			ST_NB_RS2: begin
				uses_alu = 1'b1; alu_a = rs_q; alu_b = rs_q;
				post_x = d2_q; post_sub = 1'b1; use_pw = 1'b1;
			end
			ST_NB_DIST: begin
				uses_alu = 1'b1; alu_op = ALU_SQRT; alu_a = d2_q;
			end
			ST_NB_UX: begin
				uses_alu = 1'b1; alu_op = ALU_DIV; alu_a = d_q[0]; alu_b = dist_q;
			end
			ST_NB_UY: begin
				uses_alu = 1'b1; alu_op = ALU_DIV; alu_a = d_q[1]; alu_b = dist_q;
			end
			ST_NB_UZ: begin
				uses_alu = 1'b1; alu_op = ALU_DIV; alu_a = d_q[2]; alu_b = dist_q;
			end
			ST_NB_KSUM: begin
				post_x = own_kpr_q; post_y = k2_q; use_pw = 1'b1;
			end
			ST_NB_KPROD: begin
				uses_alu = 1'b1; alu_a = own_kpr_q; alu_b = k2_q;
			end
			ST_NB_KEQ: begin
				uses_alu = 1'b1; alu_op = ALU_DIV; alu_a = t_q; alu_b = ksum_q;
			end
			ST_NB_GAP: begin
				post_x = rs_q; post_y = dist_q; post_sub = 1'b1; use_pw = 1'b1;
			end
			ST_NB_FE: begin
				uses_alu = 1'b1; alu_a = keq_q; alu_b = t_q;
			end
			ST_NB_DAMP: begin
				post_x = own_damp_q; post_y = c2_q; use_pw = 1'b1;
			end
			ST_NB_MSUM: begin
				post_x = own_mass_q; post_y = m2_q; use_pw = 1'b1;
			end
			ST_NB_MPROD: begin
				uses_alu = 1'b1; alu_a = own_mass_q; alu_b = m2_q;
			end
			ST_NB_MRED: begin
				uses_alu = 1'b1; alu_op = ALU_DIV; alu_a = t_q; alu_b = msum_q;
			end
			ST_NB_KM: begin
				uses_alu = 1'b1; alu_a = mred_q; alu_b = keq_q;
			end
			ST_NB_SQ: begin
				uses_alu = 1'b1; alu_op = ALU_SQRT; alu_a = t_q;
			end
			ST_NB_CRIT: begin
				post_x = t_q; post_y = t_q; use_pw = 1'b1;
			end
			ST_NB_COEF: begin
				uses_alu = 1'b1; alu_a = own_damp_q; alu_b = crit_q;
			end
			ST_NB_VX: begin
				uses_alu = 1'b1; alu_a = vrel_q[0]; alu_b = u_q[0];
				use_pw = 1'b1; extra_sat = vflag_q;
			end
			ST_NB_VY: begin
				uses_alu = 1'b1; alu_a = vrel_q[1]; alu_b = u_q[1];
				post_x = vn_q; use_pw = 1'b1;
			end
			ST_NB_VZ: begin
				uses_alu = 1'b1; alu_a = vrel_q[2]; alu_b = u_q[2];
				post_x = vn_q; use_pw = 1'b1;
			end
			ST_NB_FN: begin
				uses_alu = 1'b1; alu_a = coef_q; alu_b = vn_q;
				post_x = fe_q; use_pw = 1'b1;
			end
			ST_NB_FX: begin
				uses_alu = 1'b1; alu_a = fn_q; alu_b = u_q[0];
				post_x = word_t'(force_q[0]); use_po = 1'b1;
			end
			ST_NB_FY: begin
				uses_alu = 1'b1; alu_a = fn_q; alu_b = u_q[1];
				post_x = word_t'(force_q[1]); use_po = 1'b1;
			end
			ST_NB_FZ: begin
				uses_alu = 1'b1; alu_a = fn_q; alu_b = u_q[2];
				post_x = word_t'(force_q[2]); use_po = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (alu_req.start) begin
				issued_q <= 1'b1;
			end else if (alu_rsp.done) begin
				issued_q <= 1'b0;
			end
		end
	end

	// config, own state, force sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q[0]    <= '0;
			grav_q[1]    <= '0;
			grav_q[2]    <= GRAV_Z_RESET;
			tol_q        <= '0;
			own_mass_q   <= '0;
			own_radius_q <= '0;
			own_kpr_q    <= '0;
			own_damp_q   <= '0;
			sat_q        <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				own_pos_q[i] <= '0;
				own_vel_q[i] <= '0;
				force_q[i]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GRAV_X: grav_q[0] <= cfg_data;
					CFG_GRAV_Y: grav_q[1] <= cfg_data;
					CFG_GRAV_Z: grav_q[2] <= cfg_data;
					CFG_TOL:    tol_q     <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_OWN_LOAD) begin
				own_mass_q   <= cm.v;
				own_radius_q <= cr.v;
				own_damp_q   <= cdr.v;
				sat_q        <= own_load_sat;
				for (int i = 0; i < 3; i++) begin
					own_pos_q[i] <= cpos[i].v;
					own_vel_q[i] <= cvel[i].v;
				end
			end else if (compute && step_done) begin
				sat_q <= sat_q | (uses_alu & alu_rsp.sat) | (use_pw & pw.sat)
				       | (use_po & po.sat) | extra_sat;
				case (state_q)
					ST_OWN_KPR:          own_kpr_q  <= alu_res;
					ST_OWN_GX, ST_NB_FX: force_q[0] <= po.v;
					ST_OWN_GY, ST_NB_FY: force_q[1] <= po.v;
					ST_OWN_GZ, ST_NB_FZ: force_q[2] <= po.v;
					default: begin
					end
				endcase
			end
		end
	end

	// item latches and working values
	always_ff @(posedge clk) begin
		if (accept) begin
			m_raw_q      <= mass;
			r_raw_q      <= radius;
			k_raw_q      <= stiffness;
			dr_raw_q     <= damping_ratio;
			pos_raw_q[0] <= pos_x;
			pos_raw_q[1] <= pos_y;
			pos_raw_q[2] <= pos_z;
			vel_raw_q[0] <= vel_x;
			vel_raw_q[1] <= vel_y;
			vel_raw_q[2] <= vel_z;
			last_q       <= last;
		end
		if (compute && step_done) begin
			case (state_q)
				ST_OWN_LOAD: t_q <= ck.v;
				ST_NB_LOAD: begin
					m2_q    <= cm.v;
					r2_q    <= cr.v;
					t_q     <= ck.v;
					damp2_q <= cdr.v;
					rs_q    <= rsc.v;
					vflag_q <= vflag_c;
					for (int i = 0; i < 3; i++) begin
						d_q[i]    <= dnb[i].v;
						vrel_q[i] <= vr[i].v;
					end
				end
				ST_NB_K2:    k2_q   <= alu_res;
				ST_NB_C2:    c2_q   <= alu_res;
				ST_NB_DX, ST_NB_DY, ST_NB_DZ: d2_q <= pw.v;
				ST_NB_DIST:  dist_q <= alu_res;
				ST_NB_UX:    u_q[0] <= alu_res;
				ST_NB_UY:    u_q[1] <= alu_res;
				ST_NB_UZ:    u_q[2] <= alu_res;
				ST_NB_KSUM: begin
					ksum_q <= pw.v;
					keq_q  <= '0;
				end
				ST_NB_KPROD: t_q    <= alu_res;
				ST_NB_KEQ:   keq_q  <= alu_res;
				ST_NB_GAP:   t_q    <= pw.v;
				ST_NB_FE: begin
					fe_q <= alu_res;
					fn_q <= alu_res;
				end
				ST_NB_MSUM: begin
					msum_q <= pw.v;
					mred_q <= '0;
				end
				ST_NB_MPROD: t_q    <= alu_res;
				ST_NB_MRED:  mred_q <= alu_res;
				ST_NB_KM:    t_q    <= alu_res;
				ST_NB_SQ:    t_q    <= alu_res;
				ST_NB_CRIT:  crit_q <= pw.v;
				ST_NB_COEF:  coef_q <= alu_res;
				ST_NB_VX, ST_NB_VY, ST_NB_VZ: vn_q <= pw.v;
				ST_NB_FN:    fn_q   <= pw.v[IW-1] ? '0 : pw.v;
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 3; i++) begin
				force_out_q[i] <= 32'(force_q[i]);
			end
			sat_out_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign force_x   = force_out_q[0];
	assign force_y   = force_out_q[1];
	assign force_z   = force_out_q[2];
	assign saturated = sat_out_q;

endmodule

// ----- sv/dcfa_checker.sv -----
// ----------------------------------------------------------------------------
// dcfa_checker
// Port-level checks for the contact force accumulator, bound to the top.
// ----------------------------------------------------------------------------
module dcfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] force_x,
	input logic signed [31:0] force_y,
	input logic signed [31:0] force_z,
	input logic               saturated
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(force_y)
			&& $stable(force_z) && $stable(saturated))
		else $error("result changed while stalled");

	// every accepted item keeps the unit busy for at least the next cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken back to back");

	// a new result only appears out of a busy sequence
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// two busy-to-idle transitions cannot both emit while a result is held
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && in_stall |=> out_valid)
		else $error("held result dropped");

endmodule

bind dem_contact_force_accumulator_unit dcfa_checker u_dcfa_checker (.*);
